>>> src/alpcd_pkg.sv
// Package for the audio level meter / clap detector.
// Holds the item structs, register indexes, reset values and peak decay constants.
// No dependencies.
`default_nettype none

package alpcd_pkg;

  // Input item: one microphone sample (MSB first in the struct)
  typedef struct packed {
    logic signed [15:0] sample;
    logic               block_end;
    logic [31:0]        now_ms;
  } in_item_t;

  // Result item: one per block
  typedef struct packed {
    logic [15:0] level;
    logic [15:0] peak;
    logic        loud;
    logic        has_sound;
    logic        clap;
    logic [7:0]  clap_count;
  } result_t;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_CLAP_THRESHOLD  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CLAP_GAP_MS     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CLAP_WINDOW_MS  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_LOUD_THRESHOLD  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_NOISE_THRESHOLD = 3'd4;

  localparam logic [15:0] RST_CLAP_THRESHOLD  = 16'd3000;
  localparam logic [15:0] RST_CLAP_GAP_MS     = 16'd150;
  localparam logic [15:0] RST_CLAP_WINDOW_MS  = 16'd500;
  localparam logic [15:0] RST_LOUD_THRESHOLD  = 16'd2000;
  localparam logic [15:0] RST_NOISE_THRESHOLD = 16'd200;

  // peak decay: floor(peak * 995 / 1000)
  localparam logic [9:0] PEAK_DECAY_NUM = 10'd995;
  localparam logic [9:0] PEAK_DECAY_DEN = 10'd1000;
  // 32768 * 995 < 2^25
  localparam int         PROD_W         = 25;

  // floor(x / 1000) == (x * ceil(2^35 / 1000)) >> 35 for every x below 2^25
  localparam int          RECIP_SHIFT      = 35;
  localparam int          RECIP_W          = 26;
  localparam logic [25:0] PEAK_DECAY_RECIP = 26'd34359739;

  localparam logic [7:0] CLAP_COUNT_MAX = 8'd255;

  // controller -> datapath commands
  typedef struct packed {
    logic accept;       // sample transfer: accumulate
    logic start_level;  // block end: load divider with sum / count
    logic take_level;   // latch level, form peak product
    logic start_peak;   // scale product by 1/1000 into the decayed peak
    logic finish;       // block end: update peak and clap state, load result register
  } dp_cmd_t;

  // datapath -> controller status
  typedef struct packed {
    logic div_done;
  } dp_status_t;

endpackage

`default_nettype wire

>>> src/alpcd_dp.sv
// Datapath of the audio level meter: config registers, accumulator, restoring
// divider for the block mean, reciprocal-multiply peak decay, clap tracking, result register.
// Depends on alpcd_pkg.
`default_nettype none

module alpcd_dp #(
  parameter int MAX_BLOCK = 256
) (
  input  wire                              clk,
  input  wire                              rst,
  input  wire                              cfg_we,
  input  wire  [alpcd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire  [alpcd_pkg::CFG_DATA_W-1:0] cfg_data,
  input  alpcd_pkg::in_item_t              item,
  input  alpcd_pkg::dp_cmd_t               cmd,
  output alpcd_pkg::dp_status_t            status,
  output alpcd_pkg::result_t               result
);
  import alpcd_pkg::*;

  localparam int CNT_W = $clog2(MAX_BLOCK + 1);
  localparam int SUM_W = $clog2(32768 * MAX_BLOCK + 1);
  localparam int DIV_W = SUM_W;
  localparam int DVS_W = CNT_W;
  localparam int DCN_W = $clog2(DIV_W + 1);
  localparam int SCL_W = PROD_W + RECIP_W;

  // configuration
  logic [15:0] clap_threshold, clap_gap_ms, clap_window_ms;
  logic [15:0] loud_threshold, noise_threshold;

  always_ff @(posedge clk) begin
    if (rst) begin
      clap_threshold  <= RST_CLAP_THRESHOLD;
      clap_gap_ms     <= RST_CLAP_GAP_MS;
      clap_window_ms  <= RST_CLAP_WINDOW_MS;
      loud_threshold  <= RST_LOUD_THRESHOLD;
      noise_threshold <= RST_NOISE_THRESHOLD;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_CLAP_THRESHOLD:  clap_threshold  <= cfg_data;
        CFG_CLAP_GAP_MS:     clap_gap_ms     <= cfg_data;
        CFG_CLAP_WINDOW_MS:  clap_window_ms  <= cfg_data;
        CFG_LOUD_THRESHOLD:  loud_threshold  <= cfg_data;
        CFG_NOISE_THRESHOLD: noise_threshold <= cfg_data;
        default: ;
      endcase
    end
  end

  // accumulator
  logic [SUM_W-1:0] abs_sum, sum_with;
  logic [CNT_W-1:0] sample_count, count_with;
  logic [16:0]      mag;
  logic             room;

  always_comb begin
    mag = item.sample[15] ? (17'h10000 - {1'b0, item.sample}) : {1'b0, item.sample};
    room = (sample_count < CNT_W'(MAX_BLOCK));
    sum_with   = room ? (abs_sum + SUM_W'(mag)) : abs_sum;
    count_with = room ? (sample_count + CNT_W'(1)) : sample_count;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      abs_sum      <= '0;
      sample_count <= '0;
    end else if (cmd.accept) begin
      if (item.block_end) begin
        abs_sum      <= '0;
        sample_count <= '0;
      end else begin
        abs_sum      <= sum_with;
        sample_count <= count_with;
      end
    end
  end

  // restoring divider for the block mean, one quotient bit per cycle
  logic [DIV_W-1:0] div_quo;
  logic [DVS_W-1:0] div_rem, div_dvs;
  logic [DCN_W-1:0] div_cnt;
  logic [DVS_W:0]   trial, diff;
  logic             fits;

  always_comb begin
    trial = {div_rem, div_quo[DIV_W-1]};
    diff  = trial - {1'b0, div_dvs};
    fits  = (trial >= {1'b0, div_dvs});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      div_cnt <= '0;
    end else if (cmd.start_level) begin
      div_cnt <= DCN_W'(DIV_W);
    end else if (div_cnt != '0) begin
      div_cnt <= div_cnt - DCN_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start_level) begin
      div_quo <= DIV_W'(sum_with);
      div_dvs <= DVS_W'(count_with);
      div_rem <= '0;
    end else if (div_cnt != '0) begin
      div_quo <= {div_quo[DIV_W-2:0], fits};
      div_rem <= fits ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
    end
  end

  assign status.div_done = (div_cnt == '0);

  // level and peak
  logic [15:0]       level_r, peak_level, peak_max, peak_decayed;
  logic [31:0]       now_r;
  logic [PROD_W-1:0] prod;
  logic [SCL_W-1:0]  scaled;

  assign peak_max = (div_quo[15:0] > peak_level) ? div_quo[15:0] : peak_level;
  // product / 1000 by reciprocal multiply; the quotient fits in 16 bits
  assign scaled   = SCL_W'(prod) * SCL_W'(PEAK_DECAY_RECIP);

  always_ff @(posedge clk) begin
    if (cmd.start_level) now_r <= item.now_ms;
    if (cmd.take_level) begin
      level_r <= div_quo[15:0];
      prod    <= PROD_W'(peak_max) * PROD_W'(PEAK_DECAY_NUM);
    end
    if (cmd.start_peak) peak_decayed <= scaled[RECIP_SHIFT +: 16];
  end

  // clap tracking
  logic [31:0] last_clap_ms, elapsed;
  logic [7:0]  clap_counter, counter_inc, counter_next;
  logic        clap_hit;

  always_comb begin
    elapsed     = now_r - last_clap_ms;
    clap_hit    = (level_r > clap_threshold) && (elapsed > {16'b0, clap_gap_ms});
    counter_inc = (clap_counter == CLAP_COUNT_MAX) ? clap_counter : clap_counter + 8'd1;
    if (clap_hit)                              counter_next = counter_inc;
    else if (elapsed > {16'b0, clap_window_ms}) counter_next = '0;
    else                                       counter_next = clap_counter;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      peak_level   <= '0;
      last_clap_ms <= '0;
      clap_counter <= '0;
    end else if (cmd.finish) begin
      peak_level   <= peak_decayed;
      clap_counter <= counter_next;
      if (clap_hit) last_clap_ms <= now_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      result.level      <= level_r;
      result.peak       <= peak_decayed;
      result.loud       <= (level_r > loud_threshold);
      result.has_sound  <= (level_r > noise_threshold);
      result.clap       <= clap_hit;
      result.clap_count <= counter_next;
    end
  end

endmodule

`default_nettype wire

>>> src/alpcd_ctrl.sv
// Controller of the audio level meter: sequences accumulate, the mean divide,
// peak decay and result hand-off; owns the input stall and the result valid flag.
// Depends on alpcd_pkg.
`default_nettype none

module alpcd_ctrl (
  input  wire                    clk,
  input  wire                    rst,
  input  wire                    sample_valid,
  input  wire                    block_end,
  output logic                   sample_stall,
  output logic                   result_valid,
  input  wire                    result_stall,
  input  alpcd_pkg::dp_status_t  status,
  output alpcd_pkg::dp_cmd_t     cmd
);
  import alpcd_pkg::*;

  typedef enum logic [3:0] {
    ST_ACCUM     = 4'b0001,
    ST_DIV_LEVEL = 4'b0010,
    ST_PEAK      = 4'b0100,
    ST_FINISH    = 4'b1000
  } state_t;

  state_t state, state_next;
  logic   result_valid_next;
  logic   out_free;

  assign out_free = !result_valid || !result_stall;

  always_comb begin
    state_next   = state;
    cmd          = '0;
    sample_stall = 1'b1;
    unique case (state)
      ST_ACCUM: begin
        sample_stall = 1'b0;
        if (sample_valid) begin
          cmd.accept = 1'b1;
          if (block_end) begin
            cmd.start_level = 1'b1;
            state_next      = ST_DIV_LEVEL;
          end
        end
      end
      ST_DIV_LEVEL: begin
        if (status.div_done) begin
          cmd.take_level = 1'b1;
          state_next     = ST_PEAK;
        end
      end
      ST_PEAK: begin
        cmd.start_peak = 1'b1;
        state_next     = ST_FINISH;
      end
      ST_FINISH: begin
        if (out_free) begin
          cmd.finish = 1'b1;
          state_next = ST_ACCUM;
        end
      end
      default: state_next = ST_ACCUM;
    endcase
  end

  always_comb begin
    result_valid_next = result_valid;
    if (cmd.finish)                       result_valid_next = 1'b1;
    else if (result_valid && !result_stall) result_valid_next = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_ACCUM;
      result_valid <= 1'b0;
    end else begin
      state        <= state_next;
      result_valid <= result_valid_next;
    end
  end

endmodule

`default_nettype wire

>>> src/audio_level_peak_clap_detector.sv
// Audio level meter with decaying peak and clap detector.
// Throughput: a sample that does not end a block is taken without a stall; a block-end sample holds
// the input through the mean divide (one quotient bit per cycle over the DIV_W bits of the block
// sum), the peak decay and the result load. The result is loaded after the divide and the peak decay,
// later only while an earlier result waits on result_stall.
// Reset (rst, sync, active high): clears accumulator, peak and clap state; config to defaults.
`default_nettype none

module audio_level_peak_clap_detector #(
  parameter int MAX_BLOCK = 256
) (
  input  wire                              clk,
  input  wire                              rst,
  // sample channel
  input  wire                              sample_valid,
  output logic                             sample_stall,
  input  alpcd_pkg::in_item_t              sample_item,
  // result channel
  output logic                             result_valid,
  input  wire                              result_stall,
  output alpcd_pkg::result_t               result_item,
  // config write port
  input  wire                              cfg_we,
  input  wire  [alpcd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire  [alpcd_pkg::CFG_DATA_W-1:0] cfg_data
);
  import alpcd_pkg::*;

  // command / status between controller and datapath
  dp_cmd_t    cmd;
  dp_status_t status;

  // Controller: accepts samples in its accumulate state; a block-end transfer
  // kicks off the mean divide, then the peak decay, then a result load that
  // waits for the output register to be free.
  alpcd_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .block_end    (sample_item.block_end),
    .sample_stall (sample_stall),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .status       (status),
    .cmd          (cmd)
  );

  // Datapath: holds all arithmetic and state; output register is the result_item
  // port, so the next block keeps accumulating while a result waits for transfer.
  alpcd_dp #(
    .MAX_BLOCK (MAX_BLOCK)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .item      (sample_item),
    .cmd       (cmd),
    .status    (status),
    .result    (result_item)
  );

`ifndef SYNTHESIS
  // divider busy means no sample may transfer
  a_stall_while_dividing: assert property (@(posedge clk) disable iff (rst)
    !status.div_done |-> sample_stall)
    else $error("sample accepted while divider busy");

  // a flagged clap always leaves a nonzero count
  a_clap_count: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result_item.clap) |-> (result_item.clap_count != 8'd0))
    else $error("clap flagged with zero count");

  // mean of 16-bit magnitudes never exceeds 32768; decayed peak stays below it
  a_level_range: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (result_item.level <= 16'd32768 && result_item.peak < 16'd32768))
    else $error("level or peak out of range");

  // result load only happens into a free output register
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |-> (!result_valid || !result_stall))
    else $error("result overwritten before transfer");
`endif

endmodule

`default_nettype wire
